>>> design/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

	localparam int SYM_W    = 8;
	localparam int CODE_W   = 32;
	localparam int LEN_W    = 6;
	localparam int WORD_W   = 64;
	localparam int VBITS_W  = 7;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 72;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW  = 2;
	localparam int FIFO_CW  = 3;

	typedef enum logic {
		FUNC_LOAD   = 1'b0,
		FUNC_ENCODE = 1'b1
	} func_t;

	typedef struct packed {
		logic [WORD_W-1:0]  packed_word;
		logic [VBITS_W-1:0] valid_bits;
		logic               end_of_stream;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic encode;
		logic flush;
		logic in_range;
	} item_ctl_t;

endpackage

>>> design/hcbp_code_table.sv
// Code table memory: load writes one entry, encode reads one entry (registered).
module hcbp_code_table #(
	parameter int WORD_BITS    = 64,
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic                       rd_en,
	input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
	input  logic [hcbp_pkg::CODE_W-1:0] code_bits,
	input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
	output logic [hcbp_pkg::CODE_W-1:0] rd_bits,
	output logic [hcbp_pkg::LEN_W-1:0]  rd_len
);

	localparam int AW  = $clog2(SYMBOL_COUNT);
	localparam int CAP = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
	localparam int EW  = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

	logic [EW-1:0]  mem [SYMBOL_COUNT];
	logic [AW-1:0]  addr;
	logic [6:0]     len_cap;
	logic [63:0]    len_mask;
	logic [EW-1:0]  wr_entry;
	logic [EW-1:0]  rd_entry_q;

	assign addr     = symbol[AW-1:0];
	assign len_cap  = ({1'b0, code_length} > 7'(CAP)) ? 7'(CAP) : {1'b0, code_length};
	assign len_mask = (64'd1 << len_cap) - 64'd1;
	assign wr_entry = {len_cap[hcbp_pkg::LEN_W-1:0], code_bits & len_mask[hcbp_pkg::CODE_W-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[addr];
		end
	end

	assign rd_bits = rd_entry_q[hcbp_pkg::CODE_W-1:0];
	assign rd_len  = rd_entry_q[EW-1:hcbp_pkg::CODE_W];

endmodule

>>> design/hcbp_packer.sv
// Word packer: appends one code to the word buffer, splits and flushes words.
module hcbp_packer #(
	parameter int WORD_BITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  hcbp_pkg::item_ctl_t         ctl,
	input  logic [hcbp_pkg::CODE_W-1:0] bits,
	input  logic [hcbp_pkg::LEN_W-1:0]  len,
	output hcbp_pkg::push_t             push
);

	localparam logic [6:0]  WB7   = 7'(WORD_BITS);
	localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - WORD_BITS);

	logic [63:0] buf_q;
	logic [6:0]  free_q;
	logic [63:0] buf_a, buf_n, bits64, full_word, tmp;
	logic [6:0]  free_a, free_n, l7, rest, ftmp;
	logic        emit_full, emit_part, eos_full;

	assign bits64 = 64'(bits);
	assign l7     = ctl.in_range ? {1'b0, len} : 7'd0;
	assign rest   = l7 - free_q;
	assign tmp    = buf_q | (bits64 << (free_q - l7));
	assign ftmp   = free_q - l7;

	always_comb begin
		buf_a     = buf_q;
		free_a    = free_q;
		emit_full = 1'b0;
		full_word = buf_q | (bits64 >> rest);
		if (l7 == 7'd0) begin
			buf_a  = buf_q;
			free_a = free_q;
		end else if (l7 <= free_q) begin
			if (ftmp == 7'd0) begin
				emit_full = 1'b1;
				full_word = tmp;
				buf_a     = '0;
				free_a    = WB7;
			end else begin
				buf_a  = tmp;
				free_a = ftmp;
			end
		end else begin
			emit_full = 1'b1;
			buf_a     = (bits64 << (WB7 - rest)) & WMASK;
			free_a    = WB7 - rest;
		end
	end

	always_comb begin
		emit_part = ctl.flush && (free_a < WB7);
		eos_full  = ctl.flush && !emit_part;
		buf_n     = emit_part ? '0 : buf_a;
		free_n    = emit_part ? WB7 : free_a;
		push.r1.packed_word   = buf_a;
		push.r1.valid_bits    = WB7 - free_a;
		push.r1.end_of_stream = 1'b1;
		if (emit_full) begin
			push.r0.packed_word   = full_word;
			push.r0.valid_bits    = WB7;
			push.r0.end_of_stream = eos_full;
		end else begin
			push.r0 = push.r1;
		end
		push.cnt = (fire && ctl.encode) ? ({1'b0, emit_full} + {1'b0, emit_part}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			free_q <= WB7;
		end else if (fire && ctl.encode) begin
			buf_q  <= buf_n;
			free_q <= free_n;
		end
	end

endmodule

>>> design/hcbp_out_fifo.sv
// Output queue of four words: up to two pushed per cycle, one popped per transfer.
module hcbp_out_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hcbp_pkg::push_t                push,
	output logic                           room,
	output logic                           tvalid,
	input  logic                           tready,
	output logic [hcbp_pkg::M_DATA_W-1:0]  tdata,
	output logic                           tlast
);

	hcbp_pkg::result_t mem [hcbp_pkg::FIFO_DEPTH];
	logic [hcbp_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [hcbp_pkg::FIFO_CW-1:0] count_q;
	logic                         pop;
	hcbp_pkg::result_t            head;

	assign wr_ptr_1 = wr_ptr_q + 1'b1;
	assign tvalid   = (count_q != '0);
	assign pop      = tvalid && tready;
	assign room     = (count_q <= hcbp_pkg::FIFO_CW'(hcbp_pkg::FIFO_DEPTH - 2));
	assign head     = mem[rd_ptr_q];
	assign tdata    = {1'b0, head.valid_bits, head.packed_word};
	assign tlast    = head.end_of_stream;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_ptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + hcbp_pkg::FIFO_AW'(push.cnt);
			rd_ptr_q <= rd_ptr_q + hcbp_pkg::FIFO_AW'(pop);
			count_q  <= count_q + hcbp_pkg::FIFO_CW'(push.cnt) - hcbp_pkg::FIFO_CW'(pop);
		end
	end

endmodule

>>> design/huffman_code_bit_packer.sv
// Words of an encode item pass the stage and table registers, then the output queue.
// Throughput: one item per cycle; one word leaves per cycle while m_tready is high; an
// encode item stalls intake while the four-word output queue holds more than two words.
// Reset: clears pipeline control, word buffer, free-bit count and queue;
// code table contents are undefined until loaded.
module huffman_code_bit_packer #(
	parameter int WORD_BITS    = 64,
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hcbp_pkg::S_DATA_W-1:0]   s_tdata,  // symbol, code_bits, code_length
	input  logic [0:0]                      s_tuser,  // func
	input  logic                            s_tlast,  // flush
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hcbp_pkg::M_DATA_W-1:0]   m_tdata,  // packed_word, valid_bits
	output logic                            m_tlast   // end_of_stream
);

	logic [hcbp_pkg::SYM_W-1:0]  symbol;
	logic [hcbp_pkg::CODE_W-1:0] code_bits, rd_bits;
	logic [hcbp_pkg::LEN_W-1:0]  code_length, rd_len;
	logic                        accept, is_encode, in_range, fire, room;
	logic                        valid_s1;
	hcbp_pkg::item_ctl_t         ctl_s1;
	hcbp_pkg::push_t             push;

	assign symbol      = s_tdata[7:0];
	assign code_bits   = s_tdata[39:8];
	assign code_length = s_tdata[45:40];
	assign is_encode   = (s_tuser == hcbp_pkg::FUNC_ENCODE);
	assign in_range    = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
	assign accept      = s_tvalid && s_tready;
	assign fire        = valid_s1 && (!ctl_s1.encode || room);
	assign s_tready    = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s1   <= '0;
		end else if (accept) begin
			valid_s1        <= 1'b1;
			ctl_s1.encode   <= is_encode;
			ctl_s1.flush    <= s_tlast;
			ctl_s1.in_range <= in_range;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	hcbp_code_table #(
		.WORD_BITS   (WORD_BITS),
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_table (
		.clk        (clk),
		.wr_en      (accept && !is_encode && in_range),
		.rd_en      (accept && is_encode && in_range),
		.symbol     (symbol),
		.code_bits  (code_bits),
		.code_length(code_length),
		.rd_bits    (rd_bits),
		.rd_len     (rd_len)
	);

	hcbp_packer #(
		.WORD_BITS(WORD_BITS)
	) u_packer (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.ctl   (ctl_s1),
		.bits  (rd_bits),
		.len   (rd_len),
		.push  (push)
	);

	hcbp_out_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.tvalid(m_tvalid),
		.tready(m_tready),
		.tdata (m_tdata),
		.tlast (m_tlast)
	);

endmodule

>>> design/hcbp_checker.sv
// Port checker for the Huffman code bit packer, bound to the top level.
module hcbp_checker #(
	parameter int WORD_BITS = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hcbp_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - WORD_BITS);

	logic [6:0]  vb;
	logic [63:0] pad_mask, keep_mask;

	assign vb        = m_tdata[70:64];
	assign pad_mask  = (64'd1 << (7'(WORD_BITS) - vb)) - 64'd1;
	assign keep_mask = WMASK & ~pad_mask;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_vb_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (vb != 7'd0) && (vb <= 7'(WORD_BITS)))
		else $error("valid bit count out of range");

	a_full_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> vb == 7'(WORD_BITS))
		else $error("partial word without end of stream");

	a_zero_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (vb != 7'd0) && (vb <= 7'(WORD_BITS)) |->
			(m_tdata[63:0] & ~keep_mask) == 64'd0)
		else $error("padding bits not zero");

endmodule

bind huffman_code_bit_packer hcbp_checker #(.WORD_BITS(WORD_BITS)) u_hcbp_checker (.*);
